>>> rtl/core/lnp_pkg.sv
// Shared constants, action and status codes, sequencer states and the
// structs that pass between the node pool modules. No dependencies.
`default_nettype none

package lnp_pkg;

    localparam int POOL_SIZE = 16;
    localparam int IDX_W     = $clog2(POOL_SIZE);
    localparam int NODE_W    = 5;
    localparam int TOK_W     = 16;
    localparam int STEP_W    = $clog2(POOL_SIZE + 1);

    localparam logic [NODE_W-1:0] NULL_NODE = NODE_W'(POOL_SIZE);

    localparam logic [2:0] ACT_ADD    = 3'd0;
    localparam logic [2:0] ACT_REMOVE = 3'd1;
    localparam logic [2:0] ACT_CLEAR  = 3'd2;
    localparam logic [2:0] ACT_COUNT  = 3'd3;
    localparam logic [2:0] ACT_WALK   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_ZERO_TOK  = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_WRITE,
        S_OUT
    } state_t;

    // Accesses to the node memories in one cycle
    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              lk_we;
        logic [IDX_W-1:0]  lk_waddr;
        logic [NODE_W-1:0] lk_wdata;
        logic              tk_we;
        logic [IDX_W-1:0]  tk_waddr;
        logic [TOK_W-1:0]  tk_wdata;
    } mem_req_t;

    // Allocation and release requests to the free map
    typedef struct packed {
        logic             alloc;
        logic [IDX_W-1:0] alloc_idx;
        logic             release_en;
        logic [IDX_W-1:0] release_idx;
    } fm_op_t;

    typedef struct packed {
        logic [POOL_SIZE-1:0] occ;
        logic [NODE_W-1:0]    count;
        logic                 full;
        logic [IDX_W-1:0]     lowest;
    } fm_stat_t;

    typedef struct packed {
        logic [NODE_W-1:0] new_head;
        logic [1:0]        status;
        logic [TOK_W-1:0]  item_token;
        logic              last;
    } res_t;

endpackage

`default_nettype wire

>>> rtl/core/linked_list_node_pool.sv
// Top level of the linked list node pool: stream ports, output register and
// assertions. Depends on lnp_pkg, lnp_node_mem, lnp_free_map and lnp_ctrl.
`default_nettype none

// A pool of 16 nodes holds singly linked lists named by their head index
// (16 is the empty list). One request is taken at a time; s_tready is high
// only while the sequencer is idle. Every node visited is first read from
// the link and token memories through a registered read port, then
// evaluated. A walk also passes each node through the output state, which
// waits while m_tready holds it off; count, refused requests and adds to
// an empty list go straight from idle to the output state. A walk gives
// one transfer per node with m_tlast on the final one; every other request
// gives exactly one transfer with m_tlast set. The result sits in an output
// register, so the next request is accepted while it waits for m_tready.
// Node occupancy lives in flip-flops cleared by reset, so no clearing pass
// runs after reset.

module linked_list_node_pool (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // action[2:0], head[7:3], token[23:8]
    input  wire logic [23:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // new_head[4:0], status[6:5], free_nodes[11:7], item_token[27:12], zero[31:28]
    output logic [31:0]      m_tdata,
    output logic             m_tlast
);

    lnp_pkg::mem_req_t               mem_req;
    lnp_pkg::fm_op_t                 fm_op;
    lnp_pkg::fm_stat_t               fm_stat;
    lnp_pkg::res_t                   res;
    lnp_pkg::state_t                 state;
    logic [lnp_pkg::TOK_W-1:0]       tk_rdata;
    logic [lnp_pkg::NODE_W-1:0]      lk_rdata;
    logic                            res_valid;
    logic                            slot_free;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;
    logic        m_tlast_reg, m_tlast_next;

    lnp_node_mem u_mem (
        .aclk     (aclk),
        .req      (mem_req),
        .tk_rdata (tk_rdata),
        .lk_rdata (lk_rdata)
    );

    lnp_free_map u_free (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (fm_op),
        .stat    (fm_stat)
    );

    lnp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tdata[2:0]),
        .in_head   (s_tdata[7:3]),
        .in_token  (s_tdata[23:8]),
        .tk_rdata  (tk_rdata),
        .lk_rdata  (lk_rdata),
        .fm_stat   (fm_stat),
        .slot_free (slot_free),
        .mem_req   (mem_req),
        .fm_op     (fm_op),
        .res_valid (res_valid),
        .res       (res),
        .state     (state)
    );

    assign slot_free = !m_tvalid_reg || m_tready;

    // Load a new result when the register is empty or being drained
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (res_valid && slot_free) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {4'b0, res.item_token, fm_stat.count, res.status, res.new_head};
            m_tlast_next  = res.last;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Free count must track the occupancy bits
    a_count_matches_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(fm_stat.count) == 32'(lnp_pkg::POOL_SIZE) - 32'($countones(fm_stat.occ)))
        else $error("free count out of step with occupancy");

    // Only a free node is ever handed out
    a_alloc_free_node: assert property (@(posedge aclk) disable iff (!aresetn)
        fm_op.alloc |-> !fm_stat.occ[fm_op.alloc_idx])
        else $error("allocated node already in use");

    // A pool-full result reports no free nodes
    a_full_means_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[6:5] == lnp_pkg::ST_FULL) |-> (m_tdata[11:7] == '0))
        else $error("pool full reported with free nodes left");

    // A result is only produced from the output state
    a_res_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (state == lnp_pkg::S_OUT && !s_tready))
        else $error("result offered outside the output state");

endmodule

`default_nettype wire

>>> rtl/core/lnp_node_mem.sv
// Token and link memories of the node pool: one shared registered read port,
// separate write ports. Depends on lnp_pkg.
`default_nettype none

module lnp_node_mem (
    input  wire logic                     aclk,
    input  wire lnp_pkg::mem_req_t        req,
    output logic [lnp_pkg::TOK_W-1:0]     tk_rdata,
    output logic [lnp_pkg::NODE_W-1:0]    lk_rdata
);

    logic [lnp_pkg::TOK_W-1:0]  tok_mem [lnp_pkg::POOL_SIZE];
    logic [lnp_pkg::NODE_W-1:0] link_mem [lnp_pkg::POOL_SIZE];
    logic [lnp_pkg::TOK_W-1:0]  tk_rdata_reg;
    logic [lnp_pkg::NODE_W-1:0] lk_rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.tk_we) begin
            tok_mem[req.tk_waddr] <= req.tk_wdata;
        end
        if (req.rd_en) begin
            tk_rdata_reg <= tok_mem[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (req.lk_we) begin
            link_mem[req.lk_waddr] <= req.lk_wdata;
        end
        if (req.rd_en) begin
            lk_rdata_reg <= link_mem[req.rd_addr];
        end
    end

    assign tk_rdata = tk_rdata_reg;
    assign lk_rdata = lk_rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/lnp_free_map.sv
// Occupancy bits, free node count and lowest free node encoder.
// Depends on lnp_pkg.
`default_nettype none

module lnp_free_map (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire lnp_pkg::fm_op_t   op,
    output lnp_pkg::fm_stat_t      stat
);

    logic [lnp_pkg::POOL_SIZE-1:0] occ_reg, occ_next;
    logic [lnp_pkg::NODE_W-1:0]    count_reg, count_next;
    logic [lnp_pkg::IDX_W-1:0]     lowest;

    always_comb begin
        occ_next   = occ_reg;
        count_next = count_reg;
        if (op.alloc) begin
            occ_next[op.alloc_idx] = 1'b1;
            count_next = count_reg - 1'b1;
        end else if (op.release_en && occ_reg[op.release_idx]) begin
            occ_next[op.release_idx] = 1'b0;
            count_next = count_reg + 1'b1;
        end
    end

    // Scan down so the lowest free node wins
    always_comb begin
        lowest = '0;
        for (int i = lnp_pkg::POOL_SIZE - 1; i >= 0; i--) begin
            if (!occ_reg[i]) begin
                lowest = lnp_pkg::IDX_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg   <= '0;
            count_reg <= lnp_pkg::NULL_NODE;
        end else begin
            occ_reg   <= occ_next;
            count_reg <= count_next;
        end
    end

    assign stat.occ    = occ_reg;
    assign stat.count  = count_reg;
    assign stat.full   = &occ_reg;
    assign stat.lowest = lowest;

endmodule

`default_nettype wire

>>> rtl/core/lnp_ctrl.sv
// Request sequencer: walks list links through the node memories, one node
// per read/evaluate pair, and builds each result. Depends on lnp_pkg.
`default_nettype none

module lnp_ctrl (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [2:0]                in_action,
    input  wire logic [4:0]                in_head,
    input  wire logic [lnp_pkg::TOK_W-1:0] in_token,
    input  wire logic [lnp_pkg::TOK_W-1:0] tk_rdata,
    input  wire logic [lnp_pkg::NODE_W-1:0] lk_rdata,
    input  wire lnp_pkg::fm_stat_t         fm_stat,
    input  wire logic                      slot_free,
    output lnp_pkg::mem_req_t              mem_req,
    output lnp_pkg::fm_op_t                fm_op,
    output logic                           res_valid,
    output lnp_pkg::res_t                  res,
    output lnp_pkg::state_t                state
);

    lnp_pkg::state_t state_reg, state_next;

    logic [2:0]                   act_reg, act_next;
    logic [lnp_pkg::TOK_W-1:0]    tok_reg, tok_next;
    logic [lnp_pkg::NODE_W-1:0]   cur_reg, cur_next;
    logic [lnp_pkg::NODE_W-1:0]   prev_reg, prev_next;
    logic [lnp_pkg::STEP_W-1:0]   steps_reg, steps_next;
    logic [lnp_pkg::IDX_W-1:0]    alloc_reg, alloc_next;
    lnp_pkg::res_t                res_reg, res_next;

    logic [lnp_pkg::NODE_W-1:0]   in_head_cl;
    logic [lnp_pkg::IDX_W-1:0]    cur_idx;
    logic [lnp_pkg::IDX_W-1:0]    prev_idx;
    logic [lnp_pkg::TOK_W-1:0]    cur_tok;
    logic [lnp_pkg::NODE_W-1:0]   nx;
    logic [lnp_pkg::STEP_W-1:0]   steps_inc;
    logic                         stop;
    logic                         match;
    logic                         accept;

    // Shared evaluation of the node just read
    always_comb begin
        in_head_cl = (in_head >= lnp_pkg::NULL_NODE) ? lnp_pkg::NULL_NODE : in_head;
        cur_idx    = cur_reg[lnp_pkg::IDX_W-1:0];
        prev_idx   = prev_reg[lnp_pkg::IDX_W-1:0];
        cur_tok    = fm_stat.occ[cur_idx] ? tk_rdata : '0;
        nx         = (lk_rdata < lnp_pkg::NULL_NODE) ? lk_rdata : lnp_pkg::NULL_NODE;
        steps_inc  = steps_reg + 1'b1;
        stop       = (nx == lnp_pkg::NULL_NODE) ||
                     (steps_inc == lnp_pkg::STEP_W'(lnp_pkg::POOL_SIZE));
        match      = (cur_tok == tok_reg);
        accept     = (state_reg == lnp_pkg::S_IDLE) && in_valid;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lnp_pkg::S_IDLE: begin
                if (in_valid) begin
                    unique case (in_action)
                        lnp_pkg::ACT_ADD: begin
                            if (in_token == '0 || fm_stat.full ||
                                in_head_cl == lnp_pkg::NULL_NODE) begin
                                state_next = lnp_pkg::S_OUT;
                            end else begin
                                state_next = lnp_pkg::S_READ;
                            end
                        end
                        lnp_pkg::ACT_REMOVE: begin
                            if (in_token == '0 || in_head_cl == lnp_pkg::NULL_NODE) begin
                                state_next = lnp_pkg::S_OUT;
                            end else begin
                                state_next = lnp_pkg::S_READ;
                            end
                        end
                        lnp_pkg::ACT_CLEAR, lnp_pkg::ACT_WALK: begin
                            if (in_head_cl == lnp_pkg::NULL_NODE) begin
                                state_next = lnp_pkg::S_OUT;
                            end else begin
                                state_next = lnp_pkg::S_READ;
                            end
                        end
                        default: state_next = lnp_pkg::S_OUT;
                    endcase
                end
            end
            lnp_pkg::S_READ: state_next = lnp_pkg::S_EVAL;
            lnp_pkg::S_EVAL: begin
                unique case (act_reg)
                    lnp_pkg::ACT_ADD: begin
                        state_next = stop ? lnp_pkg::S_WRITE : lnp_pkg::S_READ;
                    end
                    lnp_pkg::ACT_REMOVE: begin
                        priority if (match) begin
                            state_next = lnp_pkg::S_WRITE;
                        end else if (stop) begin
                            state_next = lnp_pkg::S_OUT;
                        end else begin
                            state_next = lnp_pkg::S_READ;
                        end
                    end
                    lnp_pkg::ACT_CLEAR: begin
                        state_next = stop ? lnp_pkg::S_OUT : lnp_pkg::S_READ;
                    end
                    default: state_next = lnp_pkg::S_OUT;
                endcase
            end
            lnp_pkg::S_WRITE: state_next = lnp_pkg::S_OUT;
            lnp_pkg::S_OUT: begin
                if (slot_free) begin
                    state_next = res_reg.last ? lnp_pkg::S_IDLE : lnp_pkg::S_READ;
                end
            end
            default: state_next = lnp_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory accesses
    always_comb begin
        act_next   = act_reg;
        tok_next   = tok_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        steps_next = steps_reg;
        alloc_next = alloc_reg;
        res_next   = res_reg;
        mem_req    = '0;
        fm_op      = '0;

        unique case (state_reg)
            lnp_pkg::S_IDLE: begin
                if (accept) begin
                    act_next            = in_action;
                    tok_next            = in_token;
                    cur_next            = in_head_cl;
                    prev_next           = lnp_pkg::NULL_NODE;
                    steps_next          = '0;
                    alloc_next          = fm_stat.lowest;
                    res_next.new_head   = in_head_cl;
                    res_next.status     = lnp_pkg::ST_OK;
                    res_next.item_token = '0;
                    res_next.last       = 1'b1;
                    unique case (in_action)
                        lnp_pkg::ACT_ADD: begin
                            priority if (in_token == '0) begin
                                res_next.status = lnp_pkg::ST_ZERO_TOK;
                            end else if (fm_stat.full) begin
                                res_next.status = lnp_pkg::ST_FULL;
                            end else if (in_head_cl == lnp_pkg::NULL_NODE) begin
                                // Start a new list with the lowest free node
                                res_next.new_head = {1'b0, fm_stat.lowest};
                                mem_req.tk_we     = 1'b1;
                                mem_req.tk_waddr  = fm_stat.lowest;
                                mem_req.tk_wdata  = in_token;
                                mem_req.lk_we     = 1'b1;
                                mem_req.lk_waddr  = fm_stat.lowest;
                                mem_req.lk_wdata  = lnp_pkg::NULL_NODE;
                                fm_op.alloc       = 1'b1;
                                fm_op.alloc_idx   = fm_stat.lowest;
                            end else begin
                                res_next.status = lnp_pkg::ST_OK;
                            end
                        end
                        lnp_pkg::ACT_REMOVE: begin
                            priority if (in_token == '0) begin
                                res_next.status = lnp_pkg::ST_ZERO_TOK;
                            end else if (in_head_cl == lnp_pkg::NULL_NODE) begin
                                res_next.status = lnp_pkg::ST_NOT_FOUND;
                            end else begin
                                res_next.status = lnp_pkg::ST_OK;
                            end
                        end
                        lnp_pkg::ACT_CLEAR: res_next.new_head = lnp_pkg::NULL_NODE;
                        default: res_next.status = lnp_pkg::ST_OK;
                    endcase
                end
            end
            lnp_pkg::S_READ: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = cur_idx;
            end
            lnp_pkg::S_EVAL: begin
                unique case (act_reg)
                    lnp_pkg::ACT_ADD: begin
                        if (stop) begin
                            // Fill the new node; link the tail to it next cycle
                            mem_req.tk_we    = 1'b1;
                            mem_req.tk_waddr = alloc_reg;
                            mem_req.tk_wdata = tok_reg;
                            mem_req.lk_we    = 1'b1;
                            mem_req.lk_waddr = alloc_reg;
                            mem_req.lk_wdata = lnp_pkg::NULL_NODE;
                            fm_op.alloc      = 1'b1;
                            fm_op.alloc_idx  = alloc_reg;
                            prev_next        = cur_reg;
                        end else begin
                            cur_next   = nx;
                            steps_next = steps_inc;
                        end
                    end
                    lnp_pkg::ACT_REMOVE: begin
                        priority if (match) begin
                            if (prev_reg == lnp_pkg::NULL_NODE) begin
                                res_next.new_head = nx;
                            end else begin
                                mem_req.lk_we    = 1'b1;
                                mem_req.lk_waddr = prev_idx;
                                mem_req.lk_wdata = nx;
                            end
                            fm_op.release_en  = 1'b1;
                            fm_op.release_idx = cur_idx;
                        end else if (stop) begin
                            res_next.status = lnp_pkg::ST_NOT_FOUND;
                        end else begin
                            prev_next  = cur_reg;
                            cur_next   = nx;
                            steps_next = steps_inc;
                        end
                    end
                    lnp_pkg::ACT_CLEAR: begin
                        mem_req.lk_we     = 1'b1;
                        mem_req.lk_waddr  = cur_idx;
                        mem_req.lk_wdata  = lnp_pkg::NULL_NODE;
                        fm_op.release_en  = 1'b1;
                        fm_op.release_idx = cur_idx;
                        cur_next          = nx;
                        steps_next        = steps_inc;
                    end
                    lnp_pkg::ACT_WALK: begin
                        res_next.item_token = cur_tok;
                        res_next.last       = stop;
                        cur_next            = nx;
                        steps_next          = steps_inc;
                    end
                    default: res_next.last = 1'b1;
                endcase
            end
            lnp_pkg::S_WRITE: begin
                mem_req.lk_we = 1'b1;
                if (act_reg == lnp_pkg::ACT_ADD) begin
                    mem_req.lk_waddr = prev_idx;
                    mem_req.lk_wdata = {1'b0, alloc_reg};
                end else begin
                    // Unhook the removed node
                    mem_req.lk_waddr = cur_idx;
                    mem_req.lk_wdata = lnp_pkg::NULL_NODE;
                end
            end
            lnp_pkg::S_OUT: begin
                res_next = res_reg;
            end
            default: res_next = res_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lnp_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg   <= act_next;
        tok_reg   <= tok_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        steps_reg <= steps_next;
        alloc_reg <= alloc_next;
        res_reg   <= res_next;
    end

    assign in_ready  = (state_reg == lnp_pkg::S_IDLE);
    assign res_valid = (state_reg == lnp_pkg::S_OUT);
    assign res       = res_reg;
    assign state     = state_reg;

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Testbench for linked_list_node_pool: stream driver, result monitor and a
// built-in node pool predictor. Depends on lnp_pkg and the block's RTL.

module testbench;

    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam int RANDOM_ITEMS = 406;
    localparam int HOLD_AT      = 360;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic [lnp_pkg::NODE_W-1:0] new_head;
        logic [1:0]                 status;
        logic [lnp_pkg::NODE_W-1:0] free_nodes;
        logic [lnp_pkg::TOK_W-1:0]  item_token;
        logic                       last;
    } pool_reply_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    linked_list_node_pool u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Shadow copy of the node pool
    logic [lnp_pkg::TOK_W-1:0]  pool_tok  [lnp_pkg::POOL_SIZE];
    logic [lnp_pkg::NODE_W-1:0] pool_link [lnp_pkg::POOL_SIZE];
    bit                         pool_touched [lnp_pkg::POOL_SIZE];
    int unsigned                pool_free = lnp_pkg::POOL_SIZE;
    logic [lnp_pkg::NODE_W-1:0] last_head = lnp_pkg::NULL_NODE;

    logic [23:0]  pending_reqs [$];
    pool_reply_t  due_results  [$];
    pool_reply_t  want;
    int unsigned  n_issued   = 0;
    int unsigned  n_accepted = 0;
    int unsigned  errors     = 0;
    int unsigned  send_idle_pct = 12;
    int unsigned  recv_idle_pct = 74;
    int unsigned  stall_left = 0;
    bit           stall_done = 1'b0;
    int unsigned  cycle_count = 0;
    logic [lnp_pkg::NODE_W-1:0] slot_head [4];

    initial begin
        for (int n = 0; n < lnp_pkg::POOL_SIZE; n++) begin
            pool_tok[n]     = '0;
            pool_link[n]    = lnp_pkg::NULL_NODE;
            pool_touched[n] = 1'b0;
        end
        for (int s = 0; s < 4; s++) slot_head[s] = lnp_pkg::NULL_NODE;
    end

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic logic [lnp_pkg::NODE_W-1:0] link_of(
        input logic [lnp_pkg::NODE_W-1:0] n);
        return (pool_link[n] < lnp_pkg::POOL_SIZE) ? pool_link[n] : lnp_pkg::NULL_NODE;
    endfunction

    function automatic void release_node(input logic [lnp_pkg::NODE_W-1:0] n);
        if (pool_tok[n] != '0) pool_free++;
        pool_tok[n]  = '0;
        pool_link[n] = lnp_pkg::NULL_NODE;
    endfunction

    function automatic void queue_reply(input logic [lnp_pkg::NODE_W-1:0] nh,
                                        input logic [1:0] st,
                                        input logic [lnp_pkg::TOK_W-1:0] itok,
                                        input logic lst);
        pool_reply_t r;
        r.new_head   = nh;
        r.status     = st;
        r.free_nodes = lnp_pkg::NODE_W'(pool_free);
        r.item_token = itok;
        r.last       = lst;
        due_results.push_back(r);
        last_head = nh;
    endfunction

    // Apply one request to the shadow pool and queue the results it causes
    function automatic void pool_step(input logic [23:0] req);
        logic [2:0]                 act;
        logic [lnp_pkg::NODE_W-1:0] hd, cur, prev, nx, spare;
        logic [lnp_pkg::TOK_W-1:0]  tok;
        int                         steps;
        act = req[2:0];
        hd  = req[7:3];
        tok = req[23:8];
        if (hd >= lnp_pkg::POOL_SIZE) hd = lnp_pkg::NULL_NODE;
        prev = lnp_pkg::NULL_NODE;
        cur  = hd;
        case (act)
            lnp_pkg::ACT_ADD: begin
                if (tok == '0) begin
                    queue_reply(hd, lnp_pkg::ST_ZERO_TOK, '0, 1'b1);
                    return;
                end
                spare = lnp_pkg::NULL_NODE;
                for (int n = lnp_pkg::POOL_SIZE - 1; n >= 0; n--)
                    if (pool_tok[n] == '0) spare = lnp_pkg::NODE_W'(n);
                if (spare == lnp_pkg::NULL_NODE) begin
                    queue_reply(hd, lnp_pkg::ST_FULL, '0, 1'b1);
                    return;
                end
                for (steps = 0; steps < lnp_pkg::POOL_SIZE && cur < lnp_pkg::POOL_SIZE;
                     steps++) begin
                    prev = cur;
                    cur  = link_of(cur);
                end
                pool_tok[spare]     = tok;
                pool_link[spare]    = lnp_pkg::NULL_NODE;
                pool_touched[spare] = 1'b1;
                if (pool_free > 0) pool_free--;
                // tail link is written after the new node's own link
                if (hd == lnp_pkg::NULL_NODE) hd = spare;
                else pool_link[prev] = spare;
                queue_reply(hd, lnp_pkg::ST_OK, '0, 1'b1);
            end
            lnp_pkg::ACT_REMOVE: begin
                if (tok == '0) begin
                    queue_reply(hd, lnp_pkg::ST_ZERO_TOK, '0, 1'b1);
                    return;
                end
                for (steps = 0; steps < lnp_pkg::POOL_SIZE && cur < lnp_pkg::POOL_SIZE;
                     steps++) begin
                    if (pool_tok[cur] == tok) begin
                        nx = link_of(cur);
                        if (prev == lnp_pkg::NULL_NODE) hd = nx;
                        else pool_link[prev] = nx;
                        release_node(cur);
                        queue_reply(hd, lnp_pkg::ST_OK, '0, 1'b1);
                        return;
                    end
                    prev = cur;
                    cur  = link_of(cur);
                end
                queue_reply(hd, lnp_pkg::ST_NOT_FOUND, '0, 1'b1);
            end
            lnp_pkg::ACT_CLEAR: begin
                for (steps = 0; steps < lnp_pkg::POOL_SIZE && cur < lnp_pkg::POOL_SIZE;
                     steps++) begin
                    nx = link_of(cur);
                    release_node(cur);
                    cur = nx;
                end
                queue_reply(lnp_pkg::NULL_NODE, lnp_pkg::ST_OK, '0, 1'b1);
            end
            lnp_pkg::ACT_WALK: begin
                if (hd == lnp_pkg::NULL_NODE) begin
                    queue_reply(hd, lnp_pkg::ST_OK, '0, 1'b1);
                    return;
                end
                for (steps = 0; steps < lnp_pkg::POOL_SIZE && cur < lnp_pkg::POOL_SIZE;
                     steps++) begin
                    nx = link_of(cur);
                    queue_reply(hd, lnp_pkg::ST_OK, pool_tok[cur],
                                (nx == lnp_pkg::NULL_NODE) ||
                                (steps + 1 >= lnp_pkg::POOL_SIZE));
                    cur = nx;
                end
            end
            default: queue_reply(hd, lnp_pkg::ST_OK, '0, 1'b1);
        endcase
    endfunction

    function automatic void note_mismatch(input string what, input logic [31:0] exp_v,
                                          input logic [31:0] got_v);
        errors++;
        if (errors <= 10)
            $display("mismatch %0d on %s: expected %0h, got %0h", errors, what, exp_v, got_v);
    endfunction

    // Driver: hold the item until its transfer, then load the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                pool_step(s_tdata);
                n_accepted <= n_accepted + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_reqs.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random backpressure plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!stall_done && n_accepted >= HOLD_AT) begin
            m_tready   <= 1'b0;
            stall_left <= HOLD_CYCLES;
            stall_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (due_results.size() == 0) begin
                note_mismatch("unexpected transfer", '0, m_tdata);
            end else begin
                want = due_results.pop_front();
                if (m_tdata[4:0] !== want.new_head)
                    note_mismatch("new_head", 32'(want.new_head), 32'(m_tdata[4:0]));
                if (m_tdata[6:5] !== want.status)
                    note_mismatch("status", 32'(want.status), 32'(m_tdata[6:5]));
                if (m_tdata[11:7] !== want.free_nodes)
                    note_mismatch("free_nodes", 32'(want.free_nodes), 32'(m_tdata[11:7]));
                if (m_tdata[27:12] !== want.item_token)
                    note_mismatch("item_token", 32'(want.item_token), 32'(m_tdata[27:12]));
                if (m_tlast !== want.last)
                    note_mismatch("last", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic issue(input logic [2:0] act, input logic [lnp_pkg::NODE_W-1:0] hd,
                         input logic [lnp_pkg::TOK_W-1:0] tok);
        pending_reqs.push_back({tok, hd, act});
        n_issued++;
    endtask

    task automatic wait_accepted();
        while (n_accepted != n_issued) @(negedge aclk);
    endtask

    task automatic drain();
        wait_accepted();
        while (due_results.size() != 0) @(negedge aclk);
    endtask

    function automatic logic [lnp_pkg::TOK_W-1:0] fresh_token();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r < 8) return lnp_pkg::TOK_W'($urandom);
        return lnp_pkg::TOK_W'($urandom_range(1, 40));
    endfunction

    // Prefer tokens that sit in the pool so removes mostly hit
    function automatic logic [lnp_pkg::TOK_W-1:0] victim_token();
        int n;
        n = $urandom_range(0, lnp_pkg::POOL_SIZE - 1);
        if (pool_tok[n] != '0 && $urandom_range(0, 3) != 0) return pool_tok[n];
        return fresh_token();
    endfunction

    // Any node that has been allocated once, or an out-of-range empty head
    function automatic logic [lnp_pkg::NODE_W-1:0] any_legal_head();
        int cand [$];
        for (int n = 0; n < lnp_pkg::POOL_SIZE; n++)
            if (pool_touched[n]) cand.push_back(n);
        if (cand.size() == 0 || $urandom_range(0, 3) == 0)
            return lnp_pkg::NODE_W'($urandom_range(lnp_pkg::POOL_SIZE, 31));
        return lnp_pkg::NODE_W'(cand[$urandom_range(0, cand.size() - 1)]);
    endfunction

    initial begin
        int                         slot, prev_slot, roll;
        logic [2:0]                 act;
        logic [lnp_pkg::NODE_W-1:0] hd;
        logic [lnp_pkg::TOK_W-1:0]  tok;

        // Directed: empty lists, refusals, a three-node list, then a self loop
        issue(lnp_pkg::ACT_COUNT,  lnp_pkg::NULL_NODE, 16'h0000);
        issue(lnp_pkg::ACT_WALK,   lnp_pkg::NULL_NODE, 16'h0000);
        issue(lnp_pkg::ACT_WALK,   5'd31,              16'h0000);
        issue(lnp_pkg::ACT_CLEAR,  lnp_pkg::NULL_NODE, 16'h0000);
        issue(lnp_pkg::ACT_ADD,    lnp_pkg::NULL_NODE, 16'h0000);
        issue(lnp_pkg::ACT_REMOVE, lnp_pkg::NULL_NODE, 16'h0000);
        issue(lnp_pkg::ACT_REMOVE, lnp_pkg::NULL_NODE, 16'h0005);
        issue(lnp_pkg::ACT_ADD,    lnp_pkg::NULL_NODE, 16'hFFFF);
        issue(lnp_pkg::ACT_ADD,    5'd0,               16'h0001);
        issue(lnp_pkg::ACT_ADD,    5'd0,               16'h8000);
        issue(lnp_pkg::ACT_WALK,   5'd0,               16'h0000);
        issue(lnp_pkg::ACT_REMOVE, 5'd0,               16'h0001);
        issue(lnp_pkg::ACT_REMOVE, 5'd0,               16'hFFFF);
        issue(lnp_pkg::ACT_REMOVE, 5'd2,               16'h1234);
        issue(ACT_SPARE_LO,        5'd2,               16'hA5A5);
        issue(ACT_SPARE_HI,        5'd2,               16'h5A5A);
        issue(lnp_pkg::ACT_CLEAR,  5'd2,               16'h0000);
        issue(lnp_pkg::ACT_ADD,    lnp_pkg::NULL_NODE, 16'h0005);
        issue(lnp_pkg::ACT_ADD,    5'd0,               16'h0006);
        // free the tail behind the head's back, then re-add it onto itself
        issue(lnp_pkg::ACT_CLEAR,  5'd1,               16'h0000);
        issue(lnp_pkg::ACT_ADD,    5'd0,               16'h0007);
        issue(lnp_pkg::ACT_WALK,   5'd0,               16'h0000);
        issue(lnp_pkg::ACT_ADD,    5'd0,               16'h0009);
        issue(lnp_pkg::ACT_CLEAR,  5'd0,               16'h0000);

        prev_slot = -1;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            wait_accepted();
            if (prev_slot >= 0) slot_head[prev_slot] = last_head;
            prev_slot = -1;
            if (i == 130 || i == 270 || i == 390) drain();
            if (i == 130) begin
                send_idle_pct = 74;
                recv_idle_pct = 12;
            end
            if (i == 270) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            slot = $urandom_range(0, 3);
            // open with a burst of adds so the pool runs full
            roll = (i < 20) ? 0 : $urandom_range(0, 99);
            hd   = slot_head[slot];
            tok  = fresh_token();
            if (roll < 40) begin
                act = lnp_pkg::ACT_ADD;
                prev_slot = slot;
                if (i < 20 && tok == '0) tok = 16'h0001;
            end else if (roll < 60) begin
                act = lnp_pkg::ACT_REMOVE;
                tok = victim_token();
                prev_slot = slot;
            end else if (roll < 67) begin
                act = lnp_pkg::ACT_CLEAR;
                prev_slot = slot;
            end else if (roll < 71) begin
                act = lnp_pkg::ACT_COUNT;
            end else if (roll < 87) begin
                act = lnp_pkg::ACT_WALK;
            end else if (roll < 96) begin
                act = 3'($urandom_range(lnp_pkg::ACT_ADD, ACT_SPARE_HI));
                hd  = any_legal_head();
                if (act == lnp_pkg::ACT_REMOVE) tok = victim_token();
            end else begin
                act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
            end
            issue(act, hd, tok);
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (errors == 0 && due_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/lnp_pkg.sv
rtl/core/lnp_node_mem.sv
rtl/core/lnp_free_map.sv
rtl/core/lnp_ctrl.sv
rtl/core/linked_list_node_pool.sv
bench/testbench.sv
